// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL files, included by hsv_rgb_convert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define HSV_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Checks that a trigger implies a consequence at the same edge.
`define HSV_ASSERT_IMP(lbl, clk, rst_n, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("assertion failed");

// Checks that a trigger implies a consequence at the next edge.
`define HSV_ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/hsv_pkg.sv =====
package hsv_pkg;

    // Width of every pixel field on the channels.
    localparam int FIELD_BITS = 16;

    // Default component width.
    localparam int COMPONENT_BITS_DEF = 16;

    // Hue scale: 1/64 degree units, one 60 degree sector and a full turn.
    localparam int unsigned HUE_SECTOR = 3840;
    localparam int unsigned HUE_FULL   = 23040;

    // Direction register codes.
    localparam logic DIR_RGB_TO_HSV = 1'b0;
    localparam logic DIR_HSV_TO_RGB = 1'b1;

    // Hue sectors for the HSV to RGB path.
    localparam logic [2:0] SECT_RED_YELLOW    = 3'd0;
    localparam logic [2:0] SECT_YELLOW_GREEN  = 3'd1;
    localparam logic [2:0] SECT_GREEN_CYAN    = 3'd2;
    localparam logic [2:0] SECT_CYAN_BLUE     = 3'd3;
    localparam logic [2:0] SECT_BLUE_MAGENTA  = 3'd4;

endpackage

// ===== hdl/hsv_if.sv =====
// Pixel input channel.
interface hsv_in_if import hsv_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] red_or_hue;
    logic [FIELD_BITS-1:0] green_or_saturation;
    logic [FIELD_BITS-1:0] blue_or_value;

    modport source (output valid, red_or_hue, green_or_saturation, blue_or_value,
                    input ready);
    modport sink (input valid, red_or_hue, green_or_saturation, blue_or_value,
                  output ready);
endinterface

// Pixel result channel.
interface hsv_out_if import hsv_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] hue_or_red;
    logic [FIELD_BITS-1:0] saturation_or_green;
    logic [FIELD_BITS-1:0] value_or_blue;

    modport source (output valid, hue_or_red, saturation_or_green, value_or_blue,
                    input ready);
    modport sink (input valid, hue_or_red, saturation_or_green, value_or_blue,
                  output ready);
endinterface

// Configuration write channel.
interface hsv_cfg_if;
    logic valid;
    logic ready;
    logic direction;

    modport source (output valid, direction, input ready);
    modport sink (input valid, direction, output ready);
endinterface

// ===== hdl/hsv_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, several lanes
// moving in lockstep with a sideband word that travels alongside.
module hsv_div #(
    parameter int NW    = 45,
    parameter int DW    = 28,
    parameter int QW    = 16,
    parameter int LANES = 3,
    parameter int SW    = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_vld,
    output logic          in_ready,
    input  logic [NW-1:0] in_num [LANES],
    input  logic [DW-1:0] in_den [LANES],
    input  logic [SW-1:0] in_side,
    output logic          out_vld,
    input  logic          out_ready,
    output logic [QW-1:0] out_quo [LANES],
    output logic [SW-1:0] out_side
);

    localparam int W = (NW > DW + QW) ? NW : DW + QW;

    logic          vld_reg  [QW+1];
    logic [W-1:0]  rem_reg  [QW+1][LANES];
    logic [DW-1:0] den_reg  [QW+1][LANES];
    logic [QW-1:0] quo_reg  [QW+1][LANES];
    logic [SW-1:0] side_reg [QW+1];
    logic [QW:0]   rdy;

    // A stage may load when it is empty or the one after it moves on.
    always_comb
    begin
        rdy[QW] = !vld_reg[QW] || out_ready;
        for (int k = QW - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    // Entry register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (rdy[0])
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_vld)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[0][l] <= W'(in_num[l]);
                den_reg[0][l] <= in_den[l];
                quo_reg[0][l] <= '0;
            end
            side_reg[0] <= in_side;
        end
    end

    // One compare and subtract per stage, most significant quotient bit first.
    for (genvar j = 1; j <= QW; j++)
    begin : g_stage
        localparam int SH = QW - j;
        logic [W-1:0]  rem_next [LANES];
        logic [QW-1:0] quo_next [LANES];

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (rem_reg[j-1][l] >= (W'(den_reg[j-1][l]) << SH))
                begin
                    rem_next[l] = rem_reg[j-1][l] - (W'(den_reg[j-1][l]) << SH);
                    quo_next[l] = quo_reg[j-1][l] | (QW'(1) << SH);
                end
                else
                begin
                    rem_next[l] = rem_reg[j-1][l];
                    quo_next[l] = quo_reg[j-1][l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (rdy[j])
            begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[j] && vld_reg[j-1])
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[j][l] <= rem_next[l];
                    den_reg[j][l] <= den_reg[j-1][l];
                    quo_reg[j][l] <= quo_next[l];
                end
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    // Entry ready, and outputs from the last stage.
    assign in_ready = rdy[0];
    assign out_vld  = vld_reg[QW];
    assign out_side = side_reg[QW];
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            out_quo[l] = quo_reg[QW][l];
        end
    end

endmodule

// ===== hdl/hsv_rgb_convert.sv =====
// Channel  | Role    | Word carried
// ---------+---------+-------------------------------------------------
// pixel    | sink    | red_or_hue, green_or_saturation, blue_or_value
// result   | source  | hue_or_red, saturation_or_green, value_or_blue
// cfg      | sink    | direction (always ready)
//
// One pixel is accepted every cycle while the result side takes words.
// The divider resolves one quotient bit per pipeline stage.
// Reset clears the valid bits and sets direction to RGB to HSV.
// A stall holds the occupied stages back to the first empty one; earlier stages keep moving and filling.
`include "assert_macros.svh"

module hsv_rgb_convert import hsv_pkg::*; #(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    hsv_in_if.sink    pixel,
    hsv_out_if.source result,
    hsv_cfg_if.sink   cfg
);

    localparam int C  = COMPONENT_BITS;
    localparam int NW = 2 * C + 13;
    localparam int DW = C + 12;
    localparam int QW = (C > 13) ? C : 13;
    localparam int unsigned FULL_CODE = (1 << C) - 1;
    localparam int unsigned FULL_HALF = FULL_CODE / 2;
    localparam int unsigned DEN       = FULL_CODE * HUE_SECTOR;
    localparam int unsigned DEN_HALF  = DEN / 2;

    typedef struct packed {
        logic               dir;
        logic signed [16:0] base;
        logic               grey;
        logic               black;
        logic [2:0]         sector;
        logic [C-1:0]       v;
    } side_t;

    // Direction register.
    logic dir_reg;
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg <= DIR_RGB_TO_HSV;
        end
        else if (cfg.valid)
        begin
            dir_reg <= cfg.direction;
        end
    end

    // Handshake chain through the stages.
    logic a_vld_reg, b_vld_reg, res_vld_reg;
    logic rdy_a, rdy_b, rdy_f, div_in_ready, div_out_vld;
    assign rdy_f       = !res_vld_reg || result.ready;
    assign rdy_b       = !b_vld_reg || div_in_ready;
    assign rdy_a       = !a_vld_reg || rdy_b;
    assign pixel.ready = rdy_a;

    // Stage A: input register.
    logic                  a_dir_reg;
    logic [FIELD_BITS-1:0] a_h_reg;
    logic [C-1:0]          a_s_reg, a_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (rdy_a)
        begin
            a_vld_reg <= pixel.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a && pixel.valid)
        begin
            a_dir_reg <= dir_reg;
            a_h_reg   <= pixel.red_or_hue;
            a_s_reg   <= pixel.green_or_saturation[C-1:0];
            a_v_reg   <= pixel.blue_or_value[C-1:0];
        end
    end

    // Stage B logic: extremes and sector for RGB, hue split and products for HSV.
    logic [C-1:0]       r_c, mx, mn, d_c;
    logic [C+1:0]       diffd_w;
    logic signed [16:0] base_c;
    logic [15:0]        h1;
    logic [2:0]         sect_c;
    logic [11:0]        frac_c;
    logic [C+11:0]      fs_c, fts_c;

    always_comb
    begin
        r_c = a_h_reg[C-1:0];
        if (r_c >= a_s_reg && r_c >= a_v_reg)
        begin
            mx      = r_c;
            mn      = (a_s_reg < a_v_reg) ? a_s_reg : a_v_reg;
            diffd_w = (C+2)'(a_s_reg) + (C+2)'(r_c - mn) - (C+2)'(a_v_reg);
            base_c  = (a_s_reg < a_v_reg) ? 17'sd19200 : -17'sd3840;
        end
        else if (a_s_reg >= a_v_reg)
        begin
            mx      = a_s_reg;
            mn      = (r_c < a_v_reg) ? r_c : a_v_reg;
            diffd_w = (C+2)'(a_v_reg) + (C+2)'(a_s_reg - mn) - (C+2)'(r_c);
            base_c  = 17'sd3840;
        end
        else
        begin
            mx      = a_v_reg;
            mn      = (r_c < a_s_reg) ? r_c : a_s_reg;
            diffd_w = (C+2)'(r_c) + (C+2)'(a_v_reg - mn) - (C+2)'(a_s_reg);
            base_c  = 17'sd11520;
        end
        d_c = mx - mn;

        if (a_h_reg >= 16'(2 * HUE_FULL))
        begin
            h1 = a_h_reg - 16'(2 * HUE_FULL);
        end
        else if (a_h_reg >= 16'(HUE_FULL))
        begin
            h1 = a_h_reg - 16'(HUE_FULL);
        end
        else
        begin
            h1 = a_h_reg;
        end
        sect_c = 3'(32'(h1 >= 16'(HUE_SECTOR)) + 32'(h1 >= 16'(2 * HUE_SECTOR))
                 + 32'(h1 >= 16'(3 * HUE_SECTOR)) + 32'(h1 >= 16'(4 * HUE_SECTOR))
                 + 32'(h1 >= 16'(5 * HUE_SECTOR)));
        frac_c = 12'(h1 - 16'(sect_c) * 16'(HUE_SECTOR));
        fs_c   = (C+12)'(frac_c) * (C+12)'(a_s_reg);
        fts_c  = (C+12)'(12'(HUE_SECTOR) - frac_c) * (C+12)'(a_s_reg);
    end

    // Stage B register.
    logic               b_dir_reg;
    logic [C-1:0]       b_v_reg, b_d_reg, b_oms_reg;
    logic [C:0]         b_diffd_reg;
    logic signed [16:0] b_base_reg;
    logic [2:0]         b_sect_reg;
    logic [C+11:0]      b_fs_reg, b_fts_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else if (rdy_b)
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_b && a_vld_reg)
        begin
            b_dir_reg   <= a_dir_reg;
            b_v_reg     <= (a_dir_reg == DIR_HSV_TO_RGB) ? a_v_reg : mx;
            b_d_reg     <= d_c;
            b_oms_reg   <= C'(FULL_CODE) - a_s_reg;
            b_diffd_reg <= diffd_w[C:0];
            b_base_reg  <= base_c;
            b_sect_reg  <= sect_c;
            b_fs_reg    <= fs_c;
            b_fts_reg   <= fts_c;
        end
    end

    // Divider operands, with the rounding half folded into the numerators of the lanes in use.
    logic [NW-1:0] div_num [3];
    logic [DW-1:0] div_den [3];
    side_t         in_side, out_side;
    logic [QW-1:0] div_quo [3];

    always_comb
    begin
        if (b_dir_reg == DIR_HSV_TO_RGB)
        begin
            div_num[0] = NW'(b_v_reg) * NW'(b_oms_reg) + NW'(FULL_HALF);
            div_den[0] = DW'(FULL_CODE);
            div_num[1] = NW'(b_v_reg) * NW'(DW'(DEN) - DW'(b_fs_reg)) + NW'(DEN_HALF);
            div_den[1] = DW'(DEN);
            div_num[2] = NW'(b_v_reg) * NW'(DW'(DEN) - DW'(b_fts_reg)) + NW'(DEN_HALF);
            div_den[2] = DW'(DEN);
        end
        else
        begin
            div_num[0] = NW'(b_diffd_reg) * NW'(2 * HUE_SECTOR) + NW'(b_d_reg);
            div_den[0] = DW'(b_d_reg) << 1;
            div_num[1] = (NW'(b_d_reg) << C) - NW'(b_d_reg) + NW'(b_v_reg >> 1);
            div_den[1] = DW'(b_v_reg);
            div_num[2] = '0;
            div_den[2] = DW'(1);
        end
        in_side.dir    = b_dir_reg;
        in_side.base   = b_base_reg;
        in_side.grey   = (b_d_reg == '0);
        in_side.black  = (b_v_reg == '0);
        in_side.sector = b_sect_reg;
        in_side.v      = b_v_reg;
    end

    hsv_div #(
        .NW    (NW),
        .DW    (DW),
        .QW    (QW),
        .LANES (3),
        .SW    ($bits(side_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_vld    (b_vld_reg),
        .in_ready  (div_in_ready),
        .in_num    (div_num),
        .in_den    (div_den),
        .in_side   (in_side),
        .out_vld   (div_out_vld),
        .out_ready (rdy_f),
        .out_quo   (div_quo),
        .out_side  (out_side)
    );

    // Final selection: hue offset and wrap, or sector mapping of p, q and t.
    logic signed [17:0] hue_raw;
    logic [C-1:0]       p_c, q_c, t_c;
    logic [15:0]        f0, f1, f2;

    always_comb
    begin
        hue_raw = 18'(out_side.base) + $signed({5'b0, div_quo[0][12:0]});
        p_c = div_quo[0][C-1:0];
        q_c = div_quo[1][C-1:0];
        t_c = div_quo[2][C-1:0];
        if (out_side.dir == DIR_RGB_TO_HSV)
        begin
            if (out_side.grey)
            begin
                f0 = '0;
            end
            else if (hue_raw >= 18'sd23040)
            begin
                f0 = 16'(hue_raw - 18'sd23040);
            end
            else
            begin
                f0 = hue_raw[15:0];
            end
            f1 = out_side.black ? '0 : 16'(div_quo[1][C-1:0]);
            f2 = 16'(out_side.v);
        end
        else
        begin
            case (out_side.sector)
                SECT_RED_YELLOW:
                begin
                    f0 = 16'(out_side.v); f1 = 16'(t_c); f2 = 16'(p_c);
                end
                SECT_YELLOW_GREEN:
                begin
                    f0 = 16'(q_c); f1 = 16'(out_side.v); f2 = 16'(p_c);
                end
                SECT_GREEN_CYAN:
                begin
                    f0 = 16'(p_c); f1 = 16'(out_side.v); f2 = 16'(t_c);
                end
                SECT_CYAN_BLUE:
                begin
                    f0 = 16'(p_c); f1 = 16'(q_c); f2 = 16'(out_side.v);
                end
                SECT_BLUE_MAGENTA:
                begin
                    f0 = 16'(t_c); f1 = 16'(p_c); f2 = 16'(out_side.v);
                end
                default:
                begin
                    f0 = 16'(out_side.v); f1 = 16'(p_c); f2 = 16'(q_c);
                end
            endcase
        end
    end

    // Output register.
    logic        res_dir_reg;
    logic [15:0] res0_reg, res1_reg, res2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (rdy_f)
        begin
            res_vld_reg <= div_out_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_f && div_out_vld)
        begin
            res_dir_reg <= out_side.dir;
            res0_reg    <= f0;
            res1_reg    <= f1;
            res2_reg    <= f2;
        end
    end

    assign result.valid               = res_vld_reg;
    assign result.hue_or_red          = res0_reg;
    assign result.saturation_or_green = res1_reg;
    assign result.value_or_blue       = res2_reg;

    // The input side only stalls when a finished word is waiting at the output.
    `HSV_ASSERT_IMP(a_stall_src, clk, rst_n, !pixel.ready, result.valid)
    // Hue never reaches a full turn.
    `HSV_ASSERT_IMP(a_hue_range, clk, rst_n,
        result.valid && res_dir_reg == DIR_RGB_TO_HSV, res0_reg < 16'(HUE_FULL))
    // A black pixel has no saturation.
    `HSV_ASSERT_IMP(a_black_sat, clk, rst_n,
        result.valid && res_dir_reg == DIR_RGB_TO_HSV && res2_reg == '0, res1_reg == '0)

endmodule
